### src/pci_pkg.sv
// Package for the conditional-integration PID core: constants, codes, shared types.
// No dependencies; used by pci_muldiv and pid_conditional_integral_core.

package pci_pkg;

	// gain denominators and decay ratio (defaults for the top-level parameters)
	localparam int PROP_DIVISOR  = 256;
	localparam int INTEG_DIVISOR = 65536;
	localparam int DERIV_DIVISOR = 256;
	localparam int DECAY_MULT    = 15;
	localparam int DECAY_DIVISOR = 16;

	localparam int TICK_MAX    = 15;
	localparam int MS_PER_TICK = 10;

	// function codes
	localparam logic [1:0] FUNC_UPDATE    = 2'd0;
	localparam logic [1:0] FUNC_CLR_INTEG = 2'd1;
	localparam logic [1:0] FUNC_RESET     = 2'd2;

	// register indexes
	localparam logic [2:0] REG_PROP_GAIN    = 3'd0;
	localparam logic [2:0] REG_INTEG_GAIN   = 3'd1;
	localparam logic [2:0] REG_DERIV_GAIN   = 3'd2;
	localparam logic [2:0] REG_I_TERM_LIMIT = 3'd3;
	localparam logic [2:0] REG_PDB_POS      = 3'd4;
	localparam logic [2:0] REG_PDB_SPEED    = 3'd5;
	localparam logic [2:0] REG_IWIN_ERR     = 3'd6;
	localparam logic [2:0] REG_IWIN_SPEED   = 3'd7;

	// multiply-divide unit status
	typedef struct packed {
		logic busy;
		logic done;
	} md_status_t;

	function automatic logic signed [15:0] sat16(input logic signed [33:0] v);
		if (v > 34'sd32767) begin
			sat16 = 16'sh7fff;
		end else if (v < -34'sd32768) begin
			sat16 = -16'sh8000;
		end else begin
			sat16 = v[15:0];
		end
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		if (v > 34'sh0_7fff_ffff) begin
			sat32 = 32'sh7fff_ffff;
		end else if (v < -34'sh0_8000_0000) begin
			sat32 = 32'sh8000_0000;
		end else begin
			sat32 = v[31:0];
		end
	endfunction

endpackage

### src/pid_conditional_integral_core.sv
// Position PID core with conditional integration and decay anti-windup.
// Uses pci_pkg and the bit-serial unit pci_muldiv.
//
//   channel | signals                                         | direction
//   --------+-------------------------------------------------+----------
//   in      | in_valid/in_stall, func, reference, position,   | to core
//           | speed, dt_ticks, integ_permit                   |
//   out     | out_valid/out_stall, drive, p_term, i_term,     | from core
//           | d_term, drive_sat, error_sat                    |
//   cfg     | cfg_we, cfg_index, cfg_data                     | to core
//
// An update beat runs up to four multiply-divide passes on one shared bit-serial unit
// (integrator bound or decay, skipped for a zero integral gain or a zero decay divisor,
// then P, I, D), each a multiply phase followed by a divide phase.
// Clear and reset beats only clear the integrator and give no result.
// in_stall is high while an update is in progress; a finished result waits in the
// output register, and the core takes the next beat meanwhile.
// Reset clears the integrator, the registers and all control state.

module pid_conditional_integral_core #(
	parameter int PROP_DIVISOR  = pci_pkg::PROP_DIVISOR,
	parameter int INTEG_DIVISOR = pci_pkg::INTEG_DIVISOR,
	parameter int DERIV_DIVISOR = pci_pkg::DERIV_DIVISOR,
	parameter int DECAY_MULT    = pci_pkg::DECAY_MULT,
	parameter int DECAY_DIVISOR = pci_pkg::DECAY_DIVISOR
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic signed [15:0] reference,
	input  logic signed [15:0] position,
	input  logic signed [15:0] speed,
	input  logic [7:0]         dt_ticks,
	input  logic               integ_permit,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] drive,
	output logic signed [15:0] p_term,
	output logic signed [15:0] i_term,
	output logic signed [15:0] d_term,
	output logic signed [15:0] drive_sat,
	output logic signed [15:0] error_sat
);

	// operand width of the shared unit: wide enough for every 16-bit gain and for INTEG_DIVISOR
	localparam int IDW = $clog2(INTEG_DIVISOR + 1);
	localparam int BW  = (IDW > 16) ? IDW : 16;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_PREP    = 4'd1;
	localparam logic [3:0] S_BOUND_W = 4'd2;
	localparam logic [3:0] S_DECAY_W = 4'd3;
	localparam logic [3:0] S_P_GO    = 4'd4;
	localparam logic [3:0] S_P_W     = 4'd5;
	localparam logic [3:0] S_I_GO    = 4'd6;
	localparam logic [3:0] S_I_W     = 4'd7;
	localparam logic [3:0] S_D_GO    = 4'd8;
	localparam logic [3:0] S_D_W     = 4'd9;
	localparam logic [3:0] S_SUM     = 4'd10;

	// configuration registers
	logic [15:0] prop_gain_q, integ_gain_q, deriv_gain_q;
	logic [14:0] i_term_limit_q;
	logic [15:0] pdb_pos_q, pdb_speed_q, iwin_err_q, iwin_speed_q;

	logic [3:0]         state_q;
	logic signed [31:0] acc_q;
	logic signed [16:0] err_q;
	logic signed [16:0] p_err_q;
	logic signed [15:0] spd_q;
	logic [7:0]         ms_q;
	logic               integ_on_q;
	logic signed [33:0] next_q;
	logic signed [31:0] p_q, i_q;
	logic               out_valid_q;

	// capture-side logic
	logic               in_accept;
	logic signed [16:0] err_in;
	logic [16:0]        aerr_in;
	logic [16:0]        aspd_in;
	logic [3:0]         ticks;

	logic               go;
	logic signed [31:0] op_a;
	logic [BW-1:0]      op_b, op_d;
	pci_pkg::md_status_t md_st;
	logic signed [31:0] md_res;

	logic signed [25:0] errms;
	logic signed [33:0] next_in;
	logic signed [33:0] bnd34;
	logic signed [31:0] i_clamped;
	logic signed [33:0] lim34;
	logic signed [33:0] drive34;
	logic               out_free;

	assign in_stall  = state_q != S_IDLE;
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	assign err_in  = 17'(reference) - 17'(position);
	assign aerr_in = err_in[16] ? 17'(-err_in) : 17'(err_in);
	assign aspd_in = speed[15] ? 17'(-17'(speed)) : 17'(17'(speed));
	assign ticks   = (dt_ticks == 8'd0) ? 4'd1 :
	                 (dt_ticks > 8'(pci_pkg::TICK_MAX)) ? 4'(pci_pkg::TICK_MAX) : dt_ticks[3:0];

	assign errms   = 26'(err_q) * $signed({18'd0, ms_q});
	assign next_in = 34'(acc_q) + 34'(errms);
	assign bnd34   = 34'(md_res);
	assign lim34   = $signed({19'd0, i_term_limit_q});

	// operand select for the launch in each state
	always_comb begin
		go   = 1'b0;
		op_a = '0;
		op_b = '0;
		op_d = '0;
		case (state_q)
			S_PREP: begin
				if (integ_on_q) begin
					go   = integ_gain_q != 16'd0;
					op_a = 32'(i_term_limit_q);
					op_b = BW'(INTEG_DIVISOR);
					op_d = BW'(integ_gain_q);
				end else begin
					go   = DECAY_DIVISOR > 0;
					op_a = acc_q;
					op_b = BW'(DECAY_MULT);
					op_d = BW'(DECAY_DIVISOR);
				end
			end
			S_P_GO: begin
				go   = 1'b1;
				op_a = 32'(p_err_q);
				op_b = BW'(prop_gain_q);
				op_d = BW'(PROP_DIVISOR);
			end
			S_I_GO: begin
				go   = 1'b1;
				op_a = acc_q;
				op_b = BW'(integ_gain_q);
				op_d = BW'(INTEG_DIVISOR);
			end
			S_D_GO: begin
				go   = 1'b1;
				op_a = 32'(spd_q);
				op_b = BW'(deriv_gain_q);
				op_d = BW'(DERIV_DIVISOR);
			end
			default: ;
		endcase
	end

	// clamp the I contribution to the term limit, then form the drive
	always_comb begin
		if (34'(i_q) > lim34) begin
			i_clamped = 32'(lim34);
		end else if (34'(i_q) < -lim34) begin
			i_clamped = 32'(-lim34);
		end else begin
			i_clamped = i_q;
		end
		drive34 = 34'(p_q) + 34'(i_clamped) - 34'(md_res);
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q    <= '0;
			integ_gain_q   <= '0;
			deriv_gain_q   <= '0;
			i_term_limit_q <= '0;
			pdb_pos_q      <= '0;
			pdb_speed_q    <= '0;
			iwin_err_q     <= '0;
			iwin_speed_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pci_pkg::REG_PROP_GAIN:    prop_gain_q    <= cfg_data;
				pci_pkg::REG_INTEG_GAIN:   integ_gain_q   <= cfg_data;
				pci_pkg::REG_DERIV_GAIN:   deriv_gain_q   <= cfg_data;
				pci_pkg::REG_I_TERM_LIMIT: i_term_limit_q <= cfg_data[14:0];
				pci_pkg::REG_PDB_POS:      pdb_pos_q      <= cfg_data;
				pci_pkg::REG_PDB_SPEED:    pdb_speed_q    <= cfg_data;
				pci_pkg::REG_IWIN_ERR:     iwin_err_q     <= cfg_data;
				pci_pkg::REG_IWIN_SPEED:   iwin_speed_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and integrator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// drop the result once the beat is taken, unless a new one replaces it
			if (out_valid_q && !out_stall && state_q != S_SUM) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						case (func)
							pci_pkg::FUNC_UPDATE:    state_q <= S_PREP;
							pci_pkg::FUNC_CLR_INTEG: acc_q   <= '0;
							pci_pkg::FUNC_RESET:     acc_q   <= '0;
							default: ;
						endcase
					end
				end
				S_PREP: begin
					if (integ_on_q) begin
						if (integ_gain_q != 16'd0) begin
							state_q <= S_BOUND_W;
						end else begin
							acc_q   <= pci_pkg::sat32(next_in);
							state_q <= S_P_GO;
						end
					end else if (DECAY_DIVISOR > 0) begin
						state_q <= S_DECAY_W;
					end else begin
						acc_q   <= '0;
						state_q <= S_P_GO;
					end
				end
				S_BOUND_W: begin
					if (md_st.done) begin
						if (next_q > bnd34) begin
							acc_q <= md_res;
						end else if (next_q < -bnd34) begin
							acc_q <= -md_res;
						end else begin
							acc_q <= pci_pkg::sat32(next_q);
						end
						state_q <= S_P_GO;
					end
				end
				S_DECAY_W: begin
					if (md_st.done) begin
						acc_q   <= md_res;
						state_q <= S_P_GO;
					end
				end
				S_P_GO:  state_q <= S_P_W;
				S_P_W:   if (md_st.done) state_q <= S_I_GO;
				S_I_GO:  state_q <= S_I_W;
				S_I_W:   if (md_st.done) state_q <= S_D_GO;
				S_D_GO:  state_q <= S_D_W;
				S_D_W:   if (md_st.done) state_q <= S_SUM;
				S_SUM: begin
					// hold until the output register is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			err_q      <= err_in;
			spd_q      <= speed;
			ms_q       <= 8'(ticks * pci_pkg::MS_PER_TICK);
			p_err_q    <= (aerr_in <= 17'(pdb_pos_q) && aspd_in <= 17'(pdb_speed_q)) ?
			              '0 : err_in;
			integ_on_q <= integ_permit && aerr_in <= 17'(iwin_err_q) &&
			              aspd_in <= 17'(iwin_speed_q);
		end
		if (state_q == S_PREP) begin
			next_q <= next_in;
		end
		if (state_q == S_P_W && md_st.done) begin
			p_q <= md_res;
		end
		if (state_q == S_I_W && md_st.done) begin
			i_q <= md_res;
		end
		// the D result stays in the unit until the sum is taken
		if (state_q == S_SUM && out_free) begin
			drive     <= drive34[31:0];
			p_term    <= pci_pkg::sat16(34'(p_q));
			i_term    <= pci_pkg::sat16(34'(i_clamped));
			d_term    <= pci_pkg::sat16(34'(md_res));
			drive_sat <= pci_pkg::sat16(drive34);
			error_sat <= pci_pkg::sat16(34'(err_q));
		end
	end

	assign out_valid = out_valid_q;

	pci_muldiv #(
		.BW(BW)
	) u_muldiv (
		.clk   (clk),
		.arst_n(arst_n),
		.go    (go),
		.a     (op_a),
		.b     (op_b),
		.d     (op_d),
		.st    (md_st),
		.res   (md_res)
	);

`ifndef SYNTHESIS
	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		go |-> !md_st.busy)
		else $error("muldiv launched while busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		md_st.done |-> !md_st.busy)
		else $error("muldiv done while still busy");

	a_cmd_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && func != pci_pkg::FUNC_UPDATE) |=> state_q == S_IDLE)
		else $error("command beat started an update");

	a_out_from_sum: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_SUM)
		else $error("result raised outside the sum step");
`endif

endmodule

### src/pci_muldiv.sv
// Bit-serial multiply-divide: res = sat32(trunc(a * b / d)), one bit per cycle.
// Uses pci_pkg (md_status_t). Instantiated by pid_conditional_integral_core.

module pci_muldiv #(
	parameter int BW = 17
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     go,
	input  logic signed [31:0]       a,
	input  logic        [BW-1:0]     b,
	input  logic        [BW-1:0]     d,
	output pci_pkg::md_status_t      st,
	output logic signed [31:0]       res
);

	localparam int PW = 32 + BW;
	localparam int CW = $clog2(PW);

	localparam logic [1:0] U_IDLE = 2'd0;
	localparam logic [1:0] U_MUL  = 2'd1;
	localparam logic [1:0] U_DIV  = 2'd2;

	logic [1:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic          sign_q;
	logic [31:0]   amag_q;
	logic [BW-1:0] b_q;
	logic [BW-1:0] d_q;
	logic [PW-1:0] prod_q;
	logic [BW-1:0] rem_q;
	logic          done_q;

	logic [BW:0]   rem_sh;
	logic          qbit;
	logic [PW-1:0] lim_neg;
	logic [PW-1:0] lim_pos;

	assign rem_sh  = {rem_q, prod_q[PW-1]};
	assign qbit    = rem_sh >= {1'b0, d_q};
	assign lim_neg = {{(PW-32){1'b0}}, 32'h8000_0000};
	assign lim_pos = {{(PW-32){1'b0}}, 32'h7fff_ffff};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= U_IDLE;
			done_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				U_IDLE: begin
					if (go) begin
						state_q <= U_MUL;
						cnt_q   <= CW'(31);
					end
				end
				U_MUL: begin
					if (cnt_q == '0) begin
						state_q <= U_DIV;
						cnt_q   <= CW'(PW - 1);
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				U_DIV: begin
					if (cnt_q == '0) begin
						state_q <= U_IDLE;
						done_q  <= 1'b1;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: state_q <= U_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			U_IDLE: begin
				if (go) begin
					sign_q <= a[31];
					amag_q <= a[31] ? 32'(-a) : 32'(a);
					b_q    <= b;
					d_q    <= d;
					prod_q <= '0;
					rem_q  <= '0;
				end
			end
			U_MUL: begin
				prod_q <= {prod_q[PW-2:0], 1'b0} + (amag_q[31] ? PW'(b_q) : '0);
				amag_q <= {amag_q[30:0], 1'b0};
			end
			U_DIV: begin
				rem_q  <= qbit ? BW'(rem_sh - {1'b0, d_q}) : rem_sh[BW-1:0];
				prod_q <= {prod_q[PW-2:0], qbit};
			end
			default: ;
		endcase
	end

	// saturate the quotient magnitude with its sign
	always_comb begin
		if (sign_q) begin
			res = (prod_q > lim_neg) ? 32'sh8000_0000 : -$signed(prod_q[31:0]);
		end else begin
			res = (prod_q > lim_pos) ? 32'sh7fff_ffff : $signed(prod_q[31:0]);
		end
	end

	assign st.busy = state_q != U_IDLE;
	assign st.done = done_q;

endmodule

### tb/sv/pid_conditional_integral_core_tb.sv
// Self-checking bench for pid_conditional_integral_core: a scoreboard class predicts each
// update result, plain tasks drive the beats and the register writes, and a process a random stall.
// Depends on pci_pkg and the core RTL only.

module pid_conditional_integral_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint I32_MAX    = 64'sd2147483647;
	localparam longint I32_MIN    = -64'sd2147483648;
	localparam int     CYCLE_CAP  = 3000000;
	localparam int     DRAIN_WAIT = 400;
	localparam int     HOLD_LEN   = 3000;

	typedef struct packed {
		logic signed [31:0] drive;
		logic signed [15:0] p_term;
		logic signed [15:0] i_term;
		logic signed [15:0] d_term;
		logic signed [15:0] drive_sat;
		logic signed [15:0] error_sat;
	} pid_result_t;

	typedef struct packed {
		logic [1:0]         func;
		logic signed [15:0] reference;
		logic signed [15:0] position;
		logic signed [15:0] speed;
		logic [7:0]         dt_ticks;
		logic               integ_permit;
	} pid_beat_t;

	// Scoreboard: owns the predicted integrator and register copies, plus the result queue.
	class pid_scoreboard;
		longint kp, ki, kd, i_lim, db_pos, db_spd, win_err, win_spd;
		longint integ;
		pid_result_t expected_q[$];
		int mismatches, checked, updates, clears;

		function new();
			kp = 0; ki = 0; kd = 0; i_lim = 0;
			db_pos = 0; db_spd = 0; win_err = 0; win_spd = 0;
			integ = 0;
			mismatches = 0; checked = 0; updates = 0; clears = 0;
		endfunction

		function longint clip(longint v, longint lo, longint hi);
			return (v > hi) ? hi : (v < lo) ? lo : v;
		endfunction

		// gain ratio: 64-bit product, truncating divide, saturate to 32 bits
		function longint scale(longint v, longint num, longint den);
			if (den <= 0) return 0;
			return clip((v * num) / den, I32_MIN, I32_MAX);
		endfunction

		function void set_reg(logic [2:0] idx, logic [15:0] data);
			case (idx)
				pci_pkg::REG_PROP_GAIN:    kp      = data;
				pci_pkg::REG_INTEG_GAIN:   ki      = data;
				pci_pkg::REG_DERIV_GAIN:   kd      = data;
				pci_pkg::REG_I_TERM_LIMIT: i_lim   = data[14:0];
				pci_pkg::REG_PDB_POS:      db_pos  = data;
				pci_pkg::REG_PDB_SPEED:    db_spd  = data;
				pci_pkg::REG_IWIN_ERR:     win_err = data;
				default:                   win_spd = data;
			endcase
		endfunction

		function void note_beat(pid_beat_t b);
			longint err, aerr, aspd, ms, nxt, bound, perr, pout, iout, dout, sum;
			int tk;
			pid_result_t r;
			if (b.func == pci_pkg::FUNC_CLR_INTEG || b.func == pci_pkg::FUNC_RESET) begin
				integ = 0;
				clears++;
				return;
			end
			if (b.func != pci_pkg::FUNC_UPDATE) return;
			updates++;
			tk = (b.dt_ticks == 0) ? 1 :
			     (b.dt_ticks > pci_pkg::TICK_MAX) ? pci_pkg::TICK_MAX : b.dt_ticks;
			ms = tk * pci_pkg::MS_PER_TICK;
			err = longint'(b.reference) - longint'(b.position);
			aerr = (err < 0) ? -err : err;
			aspd = (b.speed < 0) ? -longint'(b.speed) : longint'(b.speed);
			// P deadband needs both error and speed small
			perr = (aerr <= db_pos && aspd <= db_spd) ? 0 : err;
			if (b.integ_permit && aerr <= win_err && aspd <= win_spd) begin
				nxt = integ + err * ms;
				if (ki > 0) begin
					bound = clip(i_lim * pci_pkg::INTEG_DIVISOR / ki, 0, I32_MAX);
					nxt = clip(nxt, -bound, bound);
				end
				integ = clip(nxt, I32_MIN, I32_MAX);
			end else if (pci_pkg::DECAY_DIVISOR > 0) begin
				integ = scale(integ, pci_pkg::DECAY_MULT, pci_pkg::DECAY_DIVISOR);
			end else begin
				integ = 0;
			end
			pout = scale(perr, kp, pci_pkg::PROP_DIVISOR);
			iout = clip(scale(integ, ki, pci_pkg::INTEG_DIVISOR), -i_lim, i_lim);
			dout = scale(b.speed, kd, pci_pkg::DERIV_DIVISOR);
			sum = pout + iout - dout;
			r.drive     = sum[31:0];
			r.p_term    = clip(pout, -32768, 32767);
			r.i_term    = clip(iout, -32768, 32767);
			r.d_term    = clip(dout, -32768, 32767);
			r.drive_sat = clip(sum, -32768, 32767);
			r.error_sat = clip(err, -32768, 32767);
			expected_q.push_back(r);
		endfunction

		task report_mismatch(string what, longint got, longint want);
			mismatches++;
			$display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
		endtask

		task check_result(pid_result_t got);
			pid_result_t want;
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result beat", got.drive, 0);
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (got.drive !== want.drive) report_mismatch("drive", got.drive, want.drive);
			if (got.p_term !== want.p_term) report_mismatch("p_term", got.p_term, want.p_term);
			if (got.i_term !== want.i_term) report_mismatch("i_term", got.i_term, want.i_term);
			if (got.d_term !== want.d_term) report_mismatch("d_term", got.d_term, want.d_term);
			if (got.drive_sat !== want.drive_sat)
				report_mismatch("drive_sat", got.drive_sat, want.drive_sat);
			if (got.error_sat !== want.error_sat)
				report_mismatch("error_sat", got.error_sat, want.error_sat);
		endtask
	endclass

	logic               clk, arst_n;
	logic               cfg_we;
	logic [2:0]         cfg_index;
	logic [15:0]        cfg_data;
	logic               in_valid, in_stall;
	logic [1:0]         func;
	logic signed [15:0] reference, position, speed;
	logic [7:0]         dt_ticks;
	logic               integ_permit;
	logic               out_valid, out_stall;
	logic signed [31:0] drive;
	logic signed [15:0] p_term, i_term, d_term, drive_sat, error_sat;

	pid_scoreboard sb = new();
	int  cycles;
	bit  hold_req;
	int  burst_left;

	pid_conditional_integral_core uut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: abort the run if it never drains.
	initial begin
		cycles = 0;
		while (cycles < CYCLE_CAP) begin
			@(posedge clk);
			cycles++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Receiver: stall pattern that switches among four random modes, plus an optional long hold.
	initial begin
		int mode, hold_left, phase;
		out_stall = 1'b0;
		mode = 0; hold_left = 0; phase = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_LEN;
				hold_req = 1'b0;
			end
			if (phase % 64 == 0) mode = $urandom_range(0, 3);
			phase++;
			if (hold_left > 0) begin
				hold_left--;
				out_stall = 1'b1;
			end else begin
				case (mode)
					0: out_stall = 1'b0;
					1: out_stall = $urandom_range(0, 1);
					2: out_stall = (phase % 7) < 3;
					default: out_stall = ($urandom_range(0, 9) == 0);
				endcase
			end
		end
	end

	// Sample results at the rising edge; outputs settle in the NBA region after this read.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{drive, p_term, i_term, d_term, drive_sat, error_sat});
	end

	task automatic write_reg(logic [2:0] idx, logic [15:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		sb.set_reg(idx, data);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic write_all(logic [15:0] v [8]);
		for (int i = 0; i < 8; i++) write_reg(i[2:0], v[i]);
	endtask

	// Present one beat and hold it until the core accepts it.
	task automatic send_beat(pid_beat_t b);
		@(negedge clk);
		in_valid = 1'b1;
		{func, reference, position, speed, dt_ticks, integ_permit} = b;
		do @(posedge clk); while (in_stall);
		sb.note_beat(b);
	endtask

	// Burst pacing: drop valid for a random gap between bursts.
	task automatic paced_beat(pid_beat_t b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = $urandom_range(0, 20);
			if (gap > 0) begin
				@(negedge clk);
				in_valid = 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		send_beat(b);
	endtask

	// Wait for every expected result, then for the core's own latency.
	task automatic drain();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	function automatic pid_beat_t mk(logic [1:0] f, int r, int p, int s, int dt, bit pm);
		pid_beat_t b;
		b.func = f;
		b.reference = r[15:0];
		b.position = p[15:0];
		b.speed = s[15:0];
		b.dt_ticks = dt[7:0];
		b.integ_permit = pm;
		return b;
	endfunction

	// Mostly tracking updates near the reference so integration engages; some noise.
	function automatic pid_beat_t rand_beat();
		int r, d, s, dt, k;
		k = $urandom_range(0, 99);
		if (k < 3)
			return mk(pci_pkg::FUNC_CLR_INTEG, $urandom, $urandom, $urandom, $urandom, $urandom);
		if (k < 5)
			return mk(pci_pkg::FUNC_RESET, $urandom, $urandom, $urandom, $urandom, $urandom);
		r = $urandom_range(0, 65535) - 32768;
		if (k < 80) begin
			d = $urandom_range(0, 400) - 200;
			s = $urandom_range(0, 600) - 300;
		end else begin
			d = $urandom_range(0, 65535) - 32768;
			s = $urandom_range(0, 65535) - 32768;
		end
		dt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 15);
		return mk(pci_pkg::FUNC_UPDATE, r, r - d, s, dt, $urandom_range(0, 4) != 0);
	endfunction

	initial begin
		logic [15:0] regs [8];
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		in_valid = 1'b0;
		func = pci_pkg::FUNC_UPDATE; reference = '0; position = '0; speed = '0;
		dt_ticks = '0; integ_permit = 1'b0;
		hold_req = 1'b0;
		burst_left = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: register reset values first, then a typical tuning.
		send_beat(mk(pci_pkg::FUNC_UPDATE, 100, 0, 50, 1, 1));
		regs = '{16'd512, 16'd1000, 16'd256, 16'd20000, 16'd10, 16'd10, 16'd30000, 16'd32768};
		drain();
		write_all(regs);
		send_beat(mk(pci_pkg::FUNC_UPDATE, 32767, -32768, 32767, 0, 1));   // error beyond 16 bits
		send_beat(mk(pci_pkg::FUNC_UPDATE, -32768, 32767, -32768, 255, 1));
		send_beat(mk(pci_pkg::FUNC_UPDATE, 5, 0, 3, 15, 1));               // inside P deadband
		send_beat(mk(pci_pkg::FUNC_UPDATE, 5, 0, 11, 16, 1));              // speed outside deadband
		send_beat(mk(pci_pkg::FUNC_UPDATE, 10, 0, 10, 1, 1));              // on deadband edges
		send_beat(mk(pci_pkg::FUNC_UPDATE, 20000, 0, 0, 15, 1));           // integrate to the bound
		send_beat(mk(pci_pkg::FUNC_UPDATE, 20000, 0, 0, 15, 1));
		send_beat(mk(pci_pkg::FUNC_UPDATE, 20000, 0, 0, 15, 0));           // permit off: decay
		send_beat(mk(pci_pkg::FUNC_UPDATE, 100, -29950, 0, 8, 1));         // error window exceeded
		send_beat(mk(pci_pkg::FUNC_UPDATE, -300, 0, -32768, 8, 1));        // speed on the window edge
		send_beat(mk(pci_pkg::FUNC_CLR_INTEG, 0, 0, 0, 0, 0));
		send_beat(mk(pci_pkg::FUNC_UPDATE, -500, 0, -200, 3, 1));
		send_beat(mk(pci_pkg::FUNC_RESET, -1, -1, -1, 255, 1));
		send_beat(mk(pci_pkg::FUNC_UPDATE, 0, 0, 0, 2, 0));
		drain();

		// Random phases: extremes, all zero, then random tunings.
		for (int ph = 0; ph < 6; ph++) begin
			for (int i = 0; i < 8; i++) begin
				case (ph)
					0: regs[i] = (i == 3) ? 16'd32767 : (i == 5 || i == 7) ? 16'd32768 : 16'hffff;
					1: regs[i] = 16'd0;
					default: regs[i] = (i == 3) ? $urandom_range(0, 32767) :
						(i == 5 || i == 7) ? $urandom_range(0, 32768) : $urandom_range(0, 65535);
				endcase
			end
			if (ph >= 2 && $urandom_range(0, 1)) regs[1] = $urandom_range(1, 64);
			write_all(regs);
			for (int n = 0; n < 150; n++) begin
				if (ph == 2 && n == 40) begin
					// Long receiver hold while beats keep coming: backs up the core.
					hold_req = 1'b1;
					for (int j = 0; j < 6; j++)
						send_beat(mk(pci_pkg::FUNC_UPDATE, j * 7, 0, j, j, 1));
				end
				if (ph == 3 && n == 75) drain();
				paced_beat(rand_beat());
			end
			drain();
		end

		$display("Covered %0d updates and %0d integrator clears over 8 register settings;",
			sb.updates, sb.clears);
		$display("%0d results compared, %0d mismatches.", sb.checked, sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule
